@@ hw/rtl/arpc_pkg.sv @@
// arpc_pkg: shared types, codes and constants of the ARP cache and responder.
// No dependencies; every other file of the block refers to it by scoped name.
package arpc_pkg;

    // Cache depth default and command queue depth
    localparam int ENTRIES_DEFAULT = 32;
    localparam int QUEUE_DEPTH     = 2;

    // Operation codes of an input item
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_PACKET = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    // ARP packet fields
    localparam logic [15:0] OPC_REQUEST   = 16'd1;
    localparam logic [15:0] OPC_REPLY     = 16'd2;
    localparam logic [10:0] MIN_FRAME_LEN = 11'd42;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] peer_ip;
        logic [47:0] peer_mac;
        logic [31:0] tgt_ip;
        logic [15:0] arp_opcode;
        logic [10:0] frame_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] found_mac;
        logic        send_reply;
        logic [47:0] reply_dest_mac;
        logic [31:0] reply_target_ip;
    } t_out_item;

    // What the back end has to do with a classified transaction
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_LOOKUP,
        CMD_WRITE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [1:0]  status;
        logic        send_reply;
        logic [31:0] ip;
        logic [47:0] mac;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

@@ hw/rtl/arpc_front.sv @@
// arpc_front: accepts input transactions and classifies them into cache commands.
// Depends on arpc_pkg.
module arpc_front (
    input  logic               i_in_valid,
    input  arpc_pkg::t_in_item i_in_item,
    input  logic [31:0]        i_own_ip,
    input  arpc_pkg::t_q_flags i_q_flags,
    output logic               o_in_stall,
    output logic               o_push,
    output arpc_pkg::t_cmd     o_cmd
);

    assign o_in_stall = i_q_flags.full;
    assign o_push     = i_in_valid && !i_q_flags.full;

    always_comb begin
        o_cmd.kind       = arpc_pkg::CMD_NONE;
        o_cmd.status     = arpc_pkg::ST_DONE;
        o_cmd.send_reply = 1'b0;
        o_cmd.ip         = i_in_item.peer_ip;
        o_cmd.mac        = i_in_item.peer_mac;
        case (i_in_item.operation)
            arpc_pkg::OP_LOOKUP: begin
                o_cmd.kind = arpc_pkg::CMD_LOOKUP;
            end
            arpc_pkg::OP_ADD: begin
                o_cmd.kind = arpc_pkg::CMD_WRITE;
            end
            arpc_pkg::OP_PACKET: begin
                if (i_in_item.frame_length < arpc_pkg::MIN_FRAME_LEN) begin
                    o_cmd.status = arpc_pkg::ST_SHORT;
                end else if (i_in_item.arp_opcode == arpc_pkg::OPC_REQUEST) begin
                    // request for us: answer and learn the sender
                    if (i_in_item.tgt_ip == i_own_ip) begin
                        o_cmd.kind       = arpc_pkg::CMD_WRITE;
                        o_cmd.send_reply = 1'b1;
                    end
                end else if (i_in_item.arp_opcode == arpc_pkg::OPC_REPLY) begin
                    o_cmd.kind = arpc_pkg::CMD_WRITE;
                end
            end
            default: begin
                o_cmd.kind = arpc_pkg::CMD_NONE;
            end
        endcase
    end

endmodule

@@ hw/rtl/arpc_cmd_queue.sv @@
// arpc_cmd_queue: short FIFO of classified commands between front and back end.
// Depends on arpc_pkg.
module arpc_cmd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  arpc_pkg::t_cmd     i_cmd,
    input  logic               i_pop,
    output arpc_pkg::t_cmd     o_cmd,
    output arpc_pkg::t_q_flags o_flags
);

    localparam int DEPTH = arpc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    arpc_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd         = r_mem[r_rd_ptr];
    assign o_flags.full  = (r_count == CNT_W'(DEPTH));
    assign o_flags.empty = (r_count == '0);

endmodule

@@ hw/rtl/arpc_back.sv @@
// arpc_back: cache storage, round-robin replacement, lookup and result register.
// Depends on arpc_pkg.
module arpc_back #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  arpc_pkg::t_cmd      i_cmd,
    input  arpc_pkg::t_q_flags  i_q_flags,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output arpc_pkg::t_out_item o_out_item
);

    localparam int SLOT_W = $clog2(ENTRIES);

    typedef enum logic {
        S_IDLE,
        S_SELECT
    } t_state;

    t_state              r_state;
    logic [31:0]         r_ip  [ENTRIES];
    logic [47:0]         r_mac [ENTRIES];
    logic [ENTRIES-1:0]  r_valid;
    logic [SLOT_W-1:0]   r_next_slot;
    logic [SLOT_W-1:0]   n_next_slot;
    logic [ENTRIES-1:0]  r_match;
    logic                r_out_valid;
    arpc_pkg::t_out_item r_out;

    logic [ENTRIES-1:0]  w_match;
    logic                w_hit;
    logic [SLOT_W-1:0]   w_hit_idx;
    logic                w_out_free;
    logic                w_write;
    logic                w_out_load;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // lookups leave the queue at once, the rest only when the result can be written
    assign o_pop   = (r_state == S_IDLE) && !i_q_flags.empty &&
                     ((i_cmd.kind == arpc_pkg::CMD_LOOKUP) || w_out_free);
    assign w_write = o_pop && (i_cmd.kind == arpc_pkg::CMD_WRITE);

    // result register loads on a non-lookup pop or at the end of a lookup
    assign w_out_load = (o_pop && (i_cmd.kind != arpc_pkg::CMD_LOOKUP)) ||
                        ((r_state == S_SELECT) && w_out_free);

    assign n_next_slot = (r_next_slot == SLOT_W'(ENTRIES - 1)) ? '0
                                                               : r_next_slot + SLOT_W'(1);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_ip[i] == i_cmd.ip);
        end
    end

    // lowest matching index wins
    always_comb begin
        w_hit     = |r_match;
        w_hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                w_hit_idx = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_next_slot <= '0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_cmd.kind == arpc_pkg::CMD_LOOKUP) begin
                            r_match <= w_match;
                            r_state <= S_SELECT;
                        end else begin
                            r_out.status              <= i_cmd.status;
                            r_out.found_mac           <= '0;
                            r_out.send_reply          <= i_cmd.send_reply;
                            r_out.reply_dest_mac      <= i_cmd.send_reply ? i_cmd.mac : '0;
                            r_out.reply_target_ip     <= i_cmd.send_reply ? i_cmd.ip : '0;
                            if (w_write) begin
                                r_valid[r_next_slot] <= 1'b1;
                                r_next_slot          <= n_next_slot;
                            end
                        end
                    end
                end
                S_SELECT: begin
                    if (w_out_free) begin
                        r_out.status          <= w_hit ? arpc_pkg::ST_DONE : arpc_pkg::ST_MISS;
                        r_out.found_mac       <= w_hit ? r_mac[w_hit_idx] : '0;
                        r_out.send_reply      <= 1'b0;
                        r_out.reply_dest_mac  <= '0;
                        r_out.reply_target_ip <= '0;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_ip[r_next_slot]  <= i_cmd.ip;
            r_mac[r_next_slot] <= i_cmd.mac;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

@@ hw/rtl/arp_cache_and_responder_unit.sv @@
// arp_cache_and_responder_unit: top level of the ARP cache and receive responder.
// Depends on arpc_pkg, arpc_front, arpc_cmd_queue and arpc_back.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_stall      | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall    | o_out_item (t_out_item)
//  config  | input     | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// Flow: the front classifies a transaction in its accept cycle into a two-entry queue;
//   the back end loads the result register straight from the queue for an add, packet
//   or ignored item, and for a lookup first registers the compare vector, then selects
//   the lowest hit; the queue keeps taking transactions, until full, while a lookup selects.
// Reset: synchronous, active low; clears valid bits and replacement pointer, no pass.
// Stalls: a stalled result waits in the output register; o_in_stall only on a full queue.
//
// Config map (64-bit data): own_ip at 0x0, own_mac at 0x8; decode uses paddr[3].
module arp_cache_and_responder_unit #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  arpc_pkg::t_in_item  i_in_item,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output arpc_pkg::t_out_item o_out_item,
    // config port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    localparam logic REG_OWN_IP  = 1'b0;
    localparam logic REG_OWN_MAC = 1'b1;

    logic [31:0]        r_own_ip;
    logic [47:0]        r_own_mac;

    logic               w_push;
    logic               w_pop;
    arpc_pkg::t_cmd     w_front_cmd;
    arpc_pkg::t_cmd     w_head_cmd;
    arpc_pkg::t_q_flags w_q_flags;
    logic               w_cfg_write;

    // ---------------- config registers ----------------
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip  <= '0;
            r_own_mac <= '0;
        end else if (w_cfg_write) begin
            if (paddr[3] == REG_OWN_MAC) begin
                r_own_mac <= pwdata[47:0];
            end else begin
                r_own_ip <= pwdata[31:0];
            end
        end
    end

    // own_mac is only read back; no result field carries it
    assign prdata = (paddr[3] == REG_OWN_IP) ? {32'b0, r_own_ip} : {16'b0, r_own_mac};

    // ---------------- front: accept and classify ----------------
    arpc_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_own_ip   (r_own_ip),
        .i_q_flags  (w_q_flags),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_cmd      (w_front_cmd)
    );

    // ---------------- command queue ----------------
    arpc_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_flags (w_q_flags)
    );

    // ---------------- back: cache and results ----------------
    arpc_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_head_cmd),
        .i_q_flags   (w_q_flags),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // ---------------- assertions ----------------
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_flags.full)
        else $error("command pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_flags.empty)
        else $error("command popped from an empty queue");

    a_reply_is_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.send_reply) |->
            (o_out_item.status == arpc_pkg::ST_DONE && o_out_item.found_mac == '0))
        else $error("reply indication with lookup fields set");

    a_miss_has_no_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == arpc_pkg::ST_MISS) |->
            (o_out_item.found_mac == '0 && !o_out_item.send_reply))
        else $error("lookup miss carries data");

endmodule

@@ bench/tb_arp_cache_and_responder_unit.sv @@
`timescale 1ns / 100ps
// Testbench for arp_cache_and_responder_unit: directed and random transactions checked
// against a cycle-free cache/responder predictor. Depends on arpc_pkg and the RTL top.

// Tracks cache contents and registers, predicts one result per accepted transaction.
class arp_cache_tracker;
    logic [31:0] cache_ip [arpc_pkg::ENTRIES_DEFAULT];
    logic [47:0] cache_mac [arpc_pkg::ENTRIES_DEFAULT];
    bit          cache_valid [arpc_pkg::ENTRIES_DEFAULT];
    int unsigned next_slot;
    logic [31:0] own_ip;
    logic [47:0] own_mac;
    arpc_pkg::t_out_item pending_results [$];
    int unsigned failures;

    function new();
        foreach (cache_valid[i]) begin
            cache_valid[i] = 1'b0;
            cache_ip[i]    = '0;
            cache_mac[i]   = '0;
        end
        next_slot = 0;
        own_ip    = '0;
        own_mac   = '0;
        failures  = 0;
    endfunction

    // round-robin replacement, no duplicate check
    function void cache_insert(logic [31:0] ip, logic [47:0] mac);
        cache_ip[next_slot]    = ip;
        cache_mac[next_slot]   = mac;
        cache_valid[next_slot] = 1'b1;
        next_slot = (next_slot + 1) % arpc_pkg::ENTRIES_DEFAULT;
    endfunction

    function void note_accepted_item(arpc_pkg::t_in_item it);
        arpc_pkg::t_out_item res;
        res = '0;
        case (it.operation)
            arpc_pkg::OP_LOOKUP: begin
                res.status = arpc_pkg::ST_MISS;
                // lowest index wins
                for (int i = 0; i < arpc_pkg::ENTRIES_DEFAULT; i++) begin
                    if (cache_valid[i] && cache_ip[i] == it.peer_ip) begin
                        res.status    = arpc_pkg::ST_DONE;
                        res.found_mac = cache_mac[i];
                        break;
                    end
                end
            end
            arpc_pkg::OP_ADD: begin
                cache_insert(it.peer_ip, it.peer_mac);
            end
            arpc_pkg::OP_PACKET: begin
                if (it.frame_length < arpc_pkg::MIN_FRAME_LEN) begin
                    res.status = arpc_pkg::ST_SHORT;
                end else if (it.arp_opcode == arpc_pkg::OPC_REQUEST) begin
                    if (it.tgt_ip == own_ip) begin
                        res.send_reply      = 1'b1;
                        res.reply_dest_mac  = it.peer_mac;
                        res.reply_target_ip = it.peer_ip;
                        cache_insert(it.peer_ip, it.peer_mac);
                    end
                end else if (it.arp_opcode == arpc_pkg::OPC_REPLY) begin
                    cache_insert(it.peer_ip, it.peer_mac);
                end
            end
            default: ;
        endcase
        pending_results.push_back(res);
    endfunction

    function void report_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            failures++;
        end
    endfunction

    function void check_result(arpc_pkg::t_out_item got);
        arpc_pkg::t_out_item exp_res;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0h", $time, got);
            failures++;
            return;
        end
        exp_res = pending_results.pop_front();
        report_field("status", exp_res.status, got.status);
        report_field("found_mac", exp_res.found_mac, got.found_mac);
        report_field("send_reply", exp_res.send_reply, got.send_reply);
        report_field("reply_dest_mac", exp_res.reply_dest_mac, got.reply_dest_mac);
        report_field("reply_target_ip", exp_res.reply_target_ip, got.reply_target_ip);
    endfunction
endclass

module tb_arp_cache_and_responder_unit;

    // Operation code the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Register map, 64-bit data: register i at byte address 8*i
    localparam logic [3:0] ADDR_OWN_IP  = 4'h0;
    localparam logic [3:0] ADDR_OWN_MAC = 4'h8;

    // Worst correct run is roughly 640 transactions; keep a wide margin
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 150;
    localparam int RANDOM_PHASES = 4;
    localparam int POOL_SIZE     = 12;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    arpc_pkg::t_in_item  i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    arpc_pkg::t_out_item o_out_item;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [3:0]          paddr       = '0;
    logic [63:0]         pwdata      = '0;
    logic [63:0]         prdata;
    logic                pready;

    arp_cache_tracker tracker;
    int unsigned      cycle_count = 0;
    int unsigned      stall_left  = 0;
    bit               quiet_mode  = 1'b0;   // no gaps and no stalls while set
    logic [31:0]      ip_pool [POOL_SIZE];  // small pool so lookups hit and adds collide

    arp_cache_and_responder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: values read here are the pre-edge ones, so a transaction is
    // taken exactly when valid was high and stall low at this edge. After each
    // accepted result, draw how many cycles to hold stall before the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  = 0;
        end else if (o_out_valid && !i_out_stall) begin
            tracker.check_result(o_out_item);
            stall_left  = quiet_mode ? 0 : $urandom_range(0, 8);
            i_out_stall <= (stall_left != 0);
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= (stall_left != 0);
        end
    end

    function automatic logic [47:0] rand_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic arpc_pkg::t_in_item make_item(logic [1:0] op, logic [31:0] pip,
                                                     logic [47:0] pmac, logic [31:0] tip,
                                                     logic [15:0] opc, logic [10:0] flen);
        arpc_pkg::t_in_item it;
        it.operation    = op;
        it.peer_ip      = pip;
        it.peer_mac     = pmac;
        it.tgt_ip       = tip;
        it.arp_opcode   = opc;
        it.frame_length = flen;
        return it;
    endfunction

    // Mostly well-formed traffic on a small address pool, plus some noise
    function automatic arpc_pkg::t_in_item rand_item();
        arpc_pkg::t_in_item it;
        int unsigned        pick;
        it.operation    = arpc_pkg::OP_LOOKUP;
        it.peer_ip      = ($urandom_range(0, 3) != 0) ? ip_pool[$urandom_range(0, POOL_SIZE-1)]
                                                      : $urandom;
        it.peer_mac     = rand_mac();
        it.tgt_ip       = $urandom;
        it.arp_opcode   = 16'($urandom);
        it.frame_length = 11'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            it.operation = arpc_pkg::OP_LOOKUP;
        end else if (pick < 55) begin
            it.operation = arpc_pkg::OP_ADD;
        end else if (pick < 96) begin
            it.operation = arpc_pkg::OP_PACKET;
            pick = $urandom_range(0, 99);
            if (pick < 45)
                it.arp_opcode = arpc_pkg::OPC_REQUEST;
            else if (pick < 80)
                it.arp_opcode = arpc_pkg::OPC_REPLY;
            // requests mostly aimed at us
            if ($urandom_range(0, 9) < 6)
                it.tgt_ip = tracker.own_ip;
            pick = $urandom_range(0, 99);
            if (pick < 12)
                it.frame_length = 11'($urandom_range(0, 41));
            else if (pick < 50)
                it.frame_length = 11'($urandom_range(42, 80));
            else
                it.frame_length = 11'($urandom_range(42, 2047));
        end else begin
            it.operation = OP_UNUSED;
        end
        return it;
    endfunction

    // One transaction on the input channel; returns right after the accepting edge
    task automatic send_item(arpc_pkg::t_in_item it);
        int unsigned gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.note_accepted_item(it);
    endtask

    // Sender holds off until every expected result is back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup phase, then access phase until pready, then back to idle
    task automatic write_reg(logic [3:0] addr, logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_OWN_IP)
            tracker.own_ip = data[31:0];
        else if (addr == ADDR_OWN_MAC)
            tracker.own_mac = data[47:0];
        @(posedge i_clk);
    endtask

    initial begin
        logic [31:0]        cfg_ip;
        logic [47:0]        cfg_mac;
        arpc_pkg::t_in_item it;
        tracker = new();
        foreach (ip_pool[i]) ip_pool[i] = $urandom;

        // reset held at the start, never again
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part, registers at zero ---
        write_reg(ADDR_OWN_IP, 64'h0);
        write_reg(ADDR_OWN_MAC, 64'h0);

        // empty cache misses on both extremes
        send_item(make_item(arpc_pkg::OP_LOOKUP, 32'h0, 48'h0, 32'h0, 16'h0, 11'h0));
        send_item(make_item(arpc_pkg::OP_LOOKUP, '1, '1, '1, '1, '1));
        // extreme pairs, then a duplicate IP: the lower slot must still win
        send_item(make_item(arpc_pkg::OP_ADD, 32'h0, 48'h0, 32'h0, 16'h0, 11'h0));
        send_item(make_item(arpc_pkg::OP_ADD, '1, '1, '1, '1, '1));
        send_item(make_item(arpc_pkg::OP_LOOKUP, 32'h0, '1, '1, '1, '1));
        send_item(make_item(arpc_pkg::OP_LOOKUP, '1, 48'h0, 32'h0, 16'h0, 11'h0));
        send_item(make_item(arpc_pkg::OP_ADD, '1, 48'h0123_4567_89ab, 32'h0, 16'h0, 11'h0));
        send_item(make_item(arpc_pkg::OP_LOOKUP, '1, 48'h0, 32'h0, 16'h0, 11'h0));
        // short frames, at zero and just below the length limit
        send_item(make_item(arpc_pkg::OP_PACKET, 32'h0a00_0001, 48'h0200_0000_0001, 32'h0,
                            arpc_pkg::OPC_REQUEST, 11'd0));
        send_item(make_item(arpc_pkg::OP_PACKET, 32'h0a00_0002, 48'h0200_0000_0002, 32'h0,
                            arpc_pkg::OPC_REPLY, 11'd41));
        send_item(make_item(arpc_pkg::OP_LOOKUP, 32'h0a00_0002, 48'h0, 32'h0, 16'h0, 11'h0));
        // request for us at minimum length, request for another host at max length
        send_item(make_item(arpc_pkg::OP_PACKET, 32'hc0a8_0101, '1, 32'h0,
                            arpc_pkg::OPC_REQUEST, 11'd42));
        send_item(make_item(arpc_pkg::OP_PACKET, 32'hc0a8_0102, 48'h0200_0000_0003, 32'h1,
                            arpc_pkg::OPC_REQUEST, '1));
        send_item(make_item(arpc_pkg::OP_LOOKUP, 32'hc0a8_0101, 48'h0, 32'h0, 16'h0, 11'h0));
        send_item(make_item(arpc_pkg::OP_LOOKUP, 32'hc0a8_0102, 48'h0, 32'h0, 16'h0, 11'h0));
        // reply gets cached whatever the target
        send_item(make_item(arpc_pkg::OP_PACKET, 32'hc0a8_0103, 48'h0200_0000_0004, '1,
                            arpc_pkg::OPC_REPLY, 11'd60));
        send_item(make_item(arpc_pkg::OP_LOOKUP, 32'hc0a8_0103, 48'h0, 32'h0, 16'h0, 11'h0));
        // unknown ARP opcodes leave the cache alone
        send_item(make_item(arpc_pkg::OP_PACKET, 32'hc0a8_0104, 48'h0200_0000_0005, 32'h0,
                            16'h0, 11'd100));
        send_item(make_item(arpc_pkg::OP_PACKET, 32'hc0a8_0105, 48'h0200_0000_0006, 32'h0,
                            '1, 11'd100));
        send_item(make_item(arpc_pkg::OP_LOOKUP, 32'hc0a8_0104, 48'h0, 32'h0, 16'h0, 11'h0));
        // unused operation code: ignored, all-zero result
        send_item(make_item(OP_UNUSED, '1, '1, '1, '1, '1));
        send_item(make_item(OP_UNUSED, 32'h0, 48'h0, 32'h0, 16'h0, 11'h0));
        wait_idle();

        // --- random part, one register setting per phase ---
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin cfg_ip = '1;      cfg_mac = '1;         end
                1: begin cfg_ip = $urandom; cfg_mac = rand_mac(); end
                2: begin cfg_ip = $urandom; cfg_mac = 48'h0;      end
                default: begin cfg_ip = ip_pool[0]; cfg_mac = rand_mac(); end
            endcase
            write_reg(ADDR_OWN_IP, {32'h0, cfg_ip});
            write_reg(ADDR_OWN_MAC, {16'h0, cfg_mac});
            // turn over half the pool so old entries linger as misses
            for (int i = POOL_SIZE / 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 25 == 0)
                    quiet_mode = ($urandom_range(0, 3) == 0);
                // sender hold-off mid-stream
                if (phase == 1 && n == PHASE_ITEMS / 2)
                    wait_idle();
                it = rand_item();
                send_item(it);
            end
            quiet_mode = 1'b0;
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (tracker.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_front.sv
hw/rtl/arpc_cmd_queue.sv
hw/rtl/arpc_back.sv
hw/rtl/arp_cache_and_responder_unit.sv
bench/tb_arp_cache_and_responder_unit.sv
